// ===== hw/rtl/pced_pkg.sv =====
// ----------------------------------------------------------------------------
// pced_pkg - shared types and constants of the pin-change event dispatcher
// Pin descriptor layout, trigger codes, op codes and the pending-work
// interface between the evaluation stage and the event drain.
// ----------------------------------------------------------------------------
`default_nettype none

package pced_pkg;

  localparam int NUM_GROUPS = 3;
  localparam int PINS       = 8;
  localparam int DESC_W     = 6;

  // One pin descriptor: enable in bit 5, handler in bits 4:2, trigger in 1:0.
  typedef logic [DESC_W-1:0]              pin_desc_t;
  typedef pin_desc_t [PINS-1:0]           grp_desc_t;
  typedef grp_desc_t [NUM_GROUPS-1:0]     desc_bank_t;

  localparam int DESC_ENABLE_BIT = 5;
  localparam int DESC_HND_HI     = 4;
  localparam int DESC_HND_LO     = 2;
  localparam int DESC_TRIG_HI    = 1;
  localparam int DESC_TRIG_LO    = 0;

  localparam logic [1:0] TRIG_LOW  = 2'd0;
  localparam logic [1:0] TRIG_ANY  = 2'd1;
  localparam logic [1:0] TRIG_FALL = 2'd2;
  localparam logic [1:0] TRIG_RISE = 2'd3;

  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_PRIME = 1'b1;

  localparam logic [1:0] GRP_0 = 2'd0;
  localparam logic [1:0] GRP_1 = 2'd1;
  localparam logic [1:0] GRP_2 = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_GROUP0 = 2'd0;
  localparam logic [1:0] REG_GROUP1 = 2'd1;
  localparam logic [1:0] REG_GROUP2 = 2'd2;

  // Work handed from the evaluation stage to the drain on an accepted request.
  typedef struct packed {
    logic            load;
    logic [PINS-1:0] mask;
    logic [1:0]      grp;
  } eval_res_t;

  // Drain status seen by the top level.
  typedef struct packed {
    logic            pend_valid;
    logic [PINS-1:0] pend_mask;
  } drain_status_t;

  // Descriptor set of one group; groups outside the range read as zero.
  function automatic grp_desc_t desc_sel(input desc_bank_t bank, input logic [1:0] grp);
    grp_desc_t d;
    d = '0;
    case (grp)
      GRP_0:   d = bank[0];
      GRP_1:   d = bank[1];
      GRP_2:   d = bank[2];
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pin_change_event_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// pin_change_event_dispatcher_unit - pin-change event dispatcher, top level
// Watches three 8-bit pin groups, detects level and edge triggers per pin
// and emits one event per matching pin with its handler index.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Content
//   in_*      slave      in_tvalid / in_tready     pin sample, op, group
//   out_*     master     out_tvalid / out_tready   handler, pin, group, last
//   cfg_*     APB slave  psel & penable, pready=1  three 48-bit descriptor regs
//
// A sample request is evaluated in the cycle it is accepted, and its match mask
// enters the pending slot at the accepting edge. The first event is loaded into
// the output register once that register is empty or being emptied, which raises
// out_tvalid. Further events follow one per cycle while out_tready stays high.
// A sample that causes no event, or that has one event, can follow every cycle
// while the output is not stalled. The single pending-mask slot sets the rate:
// in_tready is low while the slot holds events, except in the cycle in which
// its last event moves into the output register, so a stalled output also
// holds off new requests.
// Reset (rst_n, synchronous) clears the previous-sample store, the descriptors
// and all valid flags; there is no clearing pass.
//
`default_nettype none

module pin_change_event_dispatcher_unit
  import pced_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] pin_sample
  input  wire logic [2:0]  in_tuser,   // [0] op, [2:1] group

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [2:0] handler_id, [5:3] pin_number, [7:6] zero
  output logic [1:0]       out_tuser,  // [1:0] source_group
  output logic             out_tlast,

  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  // Descriptor registers, one 48-bit word per group.
  desc_bank_t desc_r, desc_nxt;

  logic [1:0] reg_idx;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    desc_nxt = desc_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_GROUP0: desc_nxt[0] = cfg_pwdata[47:0];
        REG_GROUP1: desc_nxt[1] = cfg_pwdata[47:0];
        REG_GROUP2: desc_nxt[2] = cfg_pwdata[47:0];
        default:    desc_nxt = desc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= '0;
    end else begin
      desc_r <= desc_nxt;
    end
  end

  // Reads are combinational on the address; the upper 16 bits are always zero.
  always_comb begin
    case (reg_idx)
      REG_GROUP0: cfg_prdata = {16'd0, desc_r[0]};
      REG_GROUP1: cfg_prdata = {16'd0, desc_r[1]};
      REG_GROUP2: cfg_prdata = {16'd0, desc_r[2]};
      default:    cfg_prdata = '0;
    endcase
  end

  // The evaluation stage works on the request as it is accepted.
  logic          in_accept;
  logic          pend_free;
  eval_res_t     eval_res;
  drain_status_t drain_st;

  logic [2:0] ev_handler;
  logic [2:0] ev_pin;
  logic [1:0] ev_grp;
  logic       ev_last;

  assign in_tready = pend_free;
  assign in_accept = in_tvalid && in_tready;

  pced_eval u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .op     (in_tuser[0]),
    .grp    (in_tuser[2:1]),
    .sample (in_tdata),
    .desc   (desc_r),
    .res    (eval_res)
  );

  // The drain turns the match mask into events, lowest pin first.
  pced_drain u_drain (
    .clk         (clk),
    .rst_n       (rst_n),
    .res         (eval_res),
    .desc        (desc_r),
    .out_ready   (out_tready),
    .pend_free   (pend_free),
    .out_valid   (out_tvalid),
    .out_handler (ev_handler),
    .out_pin     (ev_pin),
    .out_grp     (ev_grp),
    .out_last    (ev_last),
    .status      (drain_st)
  );

  assign out_tdata = {2'b00, ev_pin, ev_handler};
  assign out_tuser = ev_grp;
  assign out_tlast = ev_last;

  // A pending slot always has at least one event left to send.
  a_pend_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    drain_st.pend_valid |-> (drain_st.pend_mask != '0))
    else $error("pending slot valid with an empty match mask");

  // A sample that loads the drain is held in the pending slot on the next cycle.
  a_load_pending: assert property (@(posedge clk) disable iff (!rst_n)
    eval_res.load |=> drain_st.pend_valid)
    else $error("matched sample did not reach the pending slot");

  // Events never name the unused fourth group.
  a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3))
    else $error("event carries an out-of-range group");

  // An empty pending slot never holds off new samples.
  a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !drain_st.pend_valid |-> in_tready)
    else $error("input stalled with no pending work");

endmodule

`default_nettype wire

// ===== hw/rtl/pced_eval.sv =====
// ----------------------------------------------------------------------------
// pced_eval - previous-sample store and trigger evaluation
// Compares an accepted sample with the stored value of its group and forms
// the mask of pins whose trigger condition is met.
// ----------------------------------------------------------------------------
`default_nettype none

module pced_eval
  import pced_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic       op,
  input  wire logic [1:0] grp,
  input  wire logic [7:0] sample,
  input  wire desc_bank_t desc,
  output eval_res_t       res
);

  logic [7:0] prev_r   [NUM_GROUPS];
  logic [7:0] prev_nxt [NUM_GROUPS];

  logic       grp_ok;
  logic [7:0] old_val;
  logic [7:0] changes;
  logic [7:0] en_vec;
  logic [7:0] match;
  grp_desc_t  gd;

  assign grp_ok = (grp == GRP_0) || (grp == GRP_1) || (grp == GRP_2);

  always_comb begin
    case (grp)
      GRP_0:   old_val = prev_r[0];
      GRP_1:   old_val = prev_r[1];
      GRP_2:   old_val = prev_r[2];
      default: old_val = '0;
    endcase
  end

  assign gd      = desc_sel(desc, grp);
  assign changes = sample ^ old_val;

  always_comb begin
    for (int n = 0; n < PINS; n++) begin
      en_vec[n] = gd[n][DESC_ENABLE_BIT];
      case (gd[n][DESC_TRIG_HI:DESC_TRIG_LO])
        TRIG_LOW:  match[n] = en_vec[n] & ~sample[n];
        TRIG_ANY:  match[n] = en_vec[n] & changes[n];
        TRIG_FALL: match[n] = en_vec[n] & changes[n] & old_val[n];
        TRIG_RISE: match[n] = en_vec[n] & changes[n] & sample[n];
        default:   match[n] = 1'b0;
      endcase
    end
  end

  // Events only follow when some enabled pin actually changed.
  always_comb begin
    res.load = accept && grp_ok && (op == OP_EVAL) && ((changes & en_vec) != '0)
               && (match != '0);
    res.mask = match;
    res.grp  = grp;
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      prev_nxt[g] = prev_r[g];
      if (accept && (grp == g[1:0])) begin
        prev_nxt[g] = sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        prev_r[g] <= '0;
      end
    end else begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        prev_r[g] <= prev_nxt[g];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pced_drain.sv =====
// ----------------------------------------------------------------------------
// pced_drain - pending match mask and event output register
// Holds the match mask of one sample and emits one event per cycle while
// the output is not stalled, lowest pin first, marking the final event.
// ----------------------------------------------------------------------------
`default_nettype none

module pced_drain
  import pced_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire eval_res_t  res,
  input  wire desc_bank_t desc,
  input  wire logic       out_ready,
  output logic            pend_free,
  output logic            out_valid,
  output logic [2:0]      out_handler,
  output logic [2:0]      out_pin,
  output logic [1:0]      out_grp,
  output logic            out_last,
  output drain_status_t   status
);

  logic            pend_valid_r, pend_valid_nxt;
  logic [PINS-1:0] pend_mask_r, pend_mask_nxt;
  logic [1:0]      pend_grp_r, pend_grp_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      out_handler_r, out_handler_nxt;
  logic [2:0]      out_pin_r, out_pin_nxt;
  logic [1:0]      out_grp_r, out_grp_nxt;
  logic            out_last_r, out_last_nxt;

  logic [PINS-1:0] low_bit;
  logic [PINS-1:0] rest;
  logic [2:0]      pin_idx;
  logic            is_last;
  logic            take;
  grp_desc_t       gd;

  assign low_bit = pend_mask_r & (~pend_mask_r + 8'd1);
  assign rest    = pend_mask_r & ~low_bit;
  assign is_last = (rest == '0);
  assign gd      = desc_sel(desc, pend_grp_r);

  always_comb begin
    pin_idx = '0;
    for (int n = PINS - 1; n >= 0; n--) begin
      if (low_bit[n]) begin
        pin_idx = n[2:0];
      end
    end
  end

  assign take      = pend_valid_r && (!out_valid_r || out_ready);
  assign pend_free = !pend_valid_r || (take && is_last);

  always_comb begin
    pend_valid_nxt  = pend_valid_r;
    pend_mask_nxt   = pend_mask_r;
    pend_grp_nxt    = pend_grp_r;
    out_valid_nxt   = out_valid_r;
    out_handler_nxt = out_handler_r;
    out_pin_nxt     = out_pin_r;
    out_grp_nxt     = out_grp_r;
    out_last_nxt    = out_last_r;

    if (take) begin
      pend_mask_nxt = rest;
      if (is_last) begin
        pend_valid_nxt = 1'b0;
      end
      out_valid_nxt   = 1'b1;
      out_handler_nxt = gd[pin_idx][DESC_HND_HI:DESC_HND_LO];
      out_pin_nxt     = pin_idx;
      out_grp_nxt     = pend_grp_r;
      out_last_nxt    = is_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // A new load only arrives when the pending slot frees up this cycle.
    if (res.load) begin
      pend_valid_nxt = 1'b1;
      pend_mask_nxt  = res.mask;
      pend_grp_nxt   = res.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_mask_r   <= pend_mask_nxt;
    pend_grp_r    <= pend_grp_nxt;
    out_handler_r <= out_handler_nxt;
    out_pin_r     <= out_pin_nxt;
    out_grp_r     <= out_grp_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_handler = out_handler_r;
  assign out_pin     = out_pin_r;
  assign out_grp     = out_grp_r;
  assign out_last    = out_last_r;

  assign status.pend_valid = pend_valid_r;
  assign status.pend_mask  = pend_mask_r;

endmodule

`default_nettype wire

// ===== test/tb_pin_change_event_dispatcher_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pin_change_event_dispatcher_unit - self-checking bench for the dispatcher
// Programs the three descriptor registers over the configuration port and
// streams pin-sample requests into the block. A behavioral model of the
// trigger logic predicts every event, and each event leaving the block is
// checked field by field against the oldest prediction. The run uses
// directed cases first, then random traffic under several idle patterns.
// ----------------------------------------------------------------------------

module tb_pin_change_event_dispatcher_unit;
  import pced_pkg::*;

  // Group code that the block must ignore, and the register index past the
  // three descriptor registers that must not change any of them.
  localparam logic [1:0] GRP_NONE   = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // One predicted dispatch event.
  typedef struct {
    logic [2:0] handler;
    logic [2:0] pin;
    logic [1:0] grp;
    logic       last;
  } pin_event_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;  // [7:0] pin_sample
  logic [2:0]  in_tuser    = '0;  // [0] op, [2:1] group
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;         // [2:0] handler_id, [5:3] pin_number, [7:6] zero
  logic [1:0]  out_tuser;         // [1:0] source_group
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [63:0] cfg_pwdata  = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow copies of the block's state, kept by the predictor.
  grp_desc_t  pin_descs   [NUM_GROUPS] = '{default: '0};
  logic [7:0] prev_levels [NUM_GROUPS] = '{default: '0};

  pin_event_t expected_events [$];
  pin_event_t seen_ev;
  int         mismatch_count     = 0;
  int         sender_idle_pct    = 0;
  int         receiver_stall_pct = 0;

  pin_change_event_dispatcher_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Every event that leaves the block is matched against the oldest
  // prediction. All values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_events.size() == 0) begin
        mismatch_count++;
        $display("%0t: event with nothing expected: expected none, actual data=%h group=%0d last=%b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        seen_ev = expected_events.pop_front();
        if (out_tdata[2:0] !== seen_ev.handler || out_tdata[5:3] !== seen_ev.pin ||
            out_tdata[7:6] !== 2'b00 || out_tuser !== seen_ev.grp ||
            out_tlast !== seen_ev.last) begin
          mismatch_count++;
          $display("%0t: event mismatch: expected handler=%0d pin=%0d pad=0 group=%0d last=%b, actual handler=%0d pin=%0d pad=%0d group=%0d last=%b",
                   $time, seen_ev.handler, seen_ev.pin, seen_ev.grp, seen_ev.last,
                   out_tdata[2:0], out_tdata[5:3], out_tdata[7:6], out_tuser, out_tlast);
        end
      end
    end
  end

  function automatic pin_desc_t make_desc(input logic en, input logic [2:0] handler,
                                          input logic [1:0] trig);
    return {en, handler, trig};
  endfunction

  // Per-pin random descriptors, mostly enabled so that events are frequent.
  function automatic grp_desc_t random_group_descs();
    grp_desc_t descs;
    for (int p = 0; p < PINS; p++) begin
      descs[p] = make_desc($urandom_range(99) < 75, 3'($urandom_range(7)),
                           2'($urandom_range(3)));
    end
    return descs;
  endfunction

  // Works out the events of one accepted sample request and updates the
  // shadow previous-sample store the way the block does.
  function automatic void predict_dispatch(input logic op, input logic [1:0] grp,
                                           input logic [7:0] levels);
    logic [7:0] prev;
    logic [7:0] changed;
    logic [7:0] enabled;
    logic       hit;
    pin_desc_t  d;
    pin_event_t ev;
    int         first_new;
    if (grp == GRP_NONE) return;
    prev = prev_levels[grp];
    prev_levels[grp] = levels;
    if (op == OP_PRIME) return;
    changed = prev ^ levels;
    for (int p = 0; p < PINS; p++) enabled[p] = pin_descs[grp][p][DESC_ENABLE_BIT];
    // Without a change on an enabled pin nothing fires, not even low level.
    if ((changed & enabled) == 8'h00) return;
    first_new = expected_events.size();
    for (int p = 0; p < PINS; p++) begin
      d = pin_descs[grp][p];
      case (d[DESC_TRIG_HI:DESC_TRIG_LO])
        TRIG_LOW:  hit = ~levels[p];
        TRIG_ANY:  hit = changed[p];
        TRIG_FALL: hit = changed[p] & prev[p];
        TRIG_RISE: hit = changed[p] & levels[p];
        default:   hit = 1'b0;
      endcase
      if (d[DESC_ENABLE_BIT] && hit) begin
        ev.handler = d[DESC_HND_HI:DESC_HND_LO];
        ev.pin     = 3'(p);
        ev.grp     = grp;
        ev.last    = 1'b0;
        expected_events.push_back(ev);
      end
    end
    if (expected_events.size() > first_new) begin
      expected_events[expected_events.size() - 1].last = 1'b1;
    end
  endfunction

  // Sends one sample request, with random idle cycles first, and predicts its
  // events at the edge where it is accepted. tvalid stays high afterwards so
  // that back-to-back requests need no extra cycle.
  task automatic send_sample(input logic op, input logic [1:0] grp, input logic [7:0] levels);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= levels;
    in_tuser  <= {grp, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_dispatch(op, grp, levels);
  endtask

  // Waits until every predicted event has come out, then lets the block
  // settle in case the last request caused no event.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_descriptors(input logic [1:0] idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 3'b000};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {16'h0000, pin_descs[idx]}) begin
      mismatch_count++;
      $display("%0t: register %0d readback mismatch: expected %h, actual %h",
               $time, idx, {16'h0000, pin_descs[idx]}, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes one register and reads it back. Bits above 47 are dropped by the
  // block; a write past the last register must leave all three unchanged.
  task automatic write_descriptors(input logic [1:0] idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    if (idx <= REG_GROUP2) begin
      pin_descs[idx] = value[47:0];
      read_descriptors(idx);
    end
  endtask

  // Hand-picked cases: each trigger mode, edges in both directions, the
  // no-change case with low-level pins, prime, the ignored group, the most
  // events from one sample and a change that matches no trigger.
  task automatic test_directed_events();
    grp_desc_t g0;
    g0[0] = make_desc(1'b1, 3'd0, TRIG_LOW);
    g0[1] = make_desc(1'b1, 3'd1, TRIG_ANY);
    g0[2] = make_desc(1'b1, 3'd2, TRIG_FALL);
    g0[3] = make_desc(1'b1, 3'd3, TRIG_RISE);
    g0[4] = make_desc(1'b1, 3'd4, TRIG_RISE);
    g0[5] = make_desc(1'b0, 3'd5, TRIG_ANY);
    g0[6] = make_desc(1'b1, 3'd6, TRIG_FALL);
    g0[7] = make_desc(1'b1, 3'd7, TRIG_ANY);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    // Descriptors are all zero after reset, so nothing may fire yet.
    send_sample(OP_EVAL, GRP_0, 8'hFF);
    send_sample(OP_EVAL, GRP_0, 8'h00);
    wait_idle();
    write_descriptors(REG_GROUP0, {16'h0000, g0});
    // All ones in every bit: every pin enabled, handler 7, rising edge.
    write_descriptors(REG_GROUP1, 64'hFFFF_FFFF_FFFF_FFFF);
    // Only pin 7, low level, handler 0.
    write_descriptors(REG_GROUP2, {16'hFFFF, make_desc(1'b1, 3'd0, TRIG_LOW), 42'h0});
    write_descriptors(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    read_descriptors(REG_GROUP0);
    read_descriptors(REG_GROUP1);
    read_descriptors(REG_GROUP2);
    send_sample(OP_EVAL, GRP_0, 8'h00);   // no change, low-level pins stay quiet
    send_sample(OP_EVAL, GRP_0, 8'hFF);   // rising on every pin
    send_sample(OP_EVAL, GRP_0, 8'h00);   // falling on every pin
    send_sample(OP_PRIME, GRP_0, 8'hA5);
    send_sample(OP_EVAL, GRP_0, 8'h5A);
    send_sample(OP_EVAL, GRP_NONE, 8'hFF);
    send_sample(OP_PRIME, GRP_NONE, 8'h00);
    send_sample(OP_EVAL, GRP_0, 8'h5B);   // change on pin 0 only
    send_sample(OP_EVAL, GRP_1, 8'hFF);   // eight events
    send_sample(OP_EVAL, GRP_1, 8'h00);   // changes, but only falling edges
    send_sample(OP_EVAL, GRP_2, 8'h80);   // pin 7 changed but is high
    send_sample(OP_EVAL, GRP_2, 8'h00);   // pin 7 changed and is low
    send_sample(OP_EVAL, GRP_2, 8'h01);   // pin 7 unchanged
    send_sample(OP_PRIME, GRP_1, 8'h00);
    send_sample(OP_EVAL, GRP_1, 8'h0F);
    send_sample(OP_EVAL, GRP_1, 8'hF0);
    wait_idle();
  endtask

  // All-zero and all-one settings for every group.
  task automatic test_register_extremes();
    for (int g = 0; g < NUM_GROUPS; g++) write_descriptors(2'(g), 64'h0);
    send_sample(OP_EVAL, GRP_0, 8'h3C);
    send_sample(OP_EVAL, GRP_1, 8'hC3);
    send_sample(OP_EVAL, GRP_2, 8'hFF);
    wait_idle();
    for (int g = 0; g < NUM_GROUPS; g++) write_descriptors(2'(g), 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(OP_EVAL, GRP_0, 8'hC3);
    send_sample(OP_EVAL, GRP_1, 8'h3C);
    send_sample(OP_EVAL, GRP_2, 8'h00);
    wait_idle();
  endtask

  // One phase of random traffic with fresh random descriptors. Most requests
  // are evaluations of random levels; primes and the ignored group are mixed
  // in at a lower rate.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int         pick;
    logic       op;
    logic [1:0] grp;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if ($urandom_range(3) == 0) begin
        write_descriptors(2'(g), {$urandom, $urandom});
      end else begin
        write_descriptors(2'(g), {16'(($urandom)), random_group_descs()});
      end
    end
    if ($urandom_range(1) == 0) write_descriptors(REG_UNUSED, {$urandom, $urandom});
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      op   = (pick >= 80 && pick < 92) ? OP_PRIME : OP_EVAL;
      grp  = (pick >= 92) ? GRP_NONE : 2'($urandom_range(2));
      send_sample(op, grp, 8'($urandom));
    end
    wait_idle();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_events();
    test_register_extremes();
    test_random_traffic(0, 0, 105);
    test_random_traffic(51, 0, 105);
    test_random_traffic(0, 51, 105);
    test_random_traffic(27, 27, 105);
    wait_idle();
    if (expected_events.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected events never arrived", $time, expected_events.size());
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #12_000_000;
    $display("%0t: timeout", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== pin_change_event_dispatcher_unit.f =====
hw/rtl/pced_pkg.sv
hw/rtl/pced_eval.sv
hw/rtl/pced_drain.sv
hw/rtl/pin_change_event_dispatcher_unit.sv
test/tb_pin_change_event_dispatcher_unit.sv
